// ----- design/bcrd_pkg.sv -----
// Shared types and constants of the compressed record decoder.
`default_nettype none

package bcrd_pkg;

  // Record type bytes, the line-close code and the space character
  localparam logic [7:0] TypeMore  = 8'hbf;
  localparam logic [7:0] TypeLast  = 8'h9f;
  localparam logic [7:0] LineClose = 8'hff;
  localparam logic [7:0] SpaceChar = 8'h20;

  // Header layout: type byte at 0, control bytes up to 5, data from 6
  localparam logic [7:0] PosCount   = 8'd1;
  localparam logic [7:0] PosSumHigh = 8'd2;
  localparam logic [7:0] PosSumLow  = 8'd3;
  localparam logic [7:0] PosLastHdr = 8'd5;
  localparam logic [7:0] PosData    = 8'd6;

  // Result status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadType  = 2'd1;
  localparam logic [1:0] StChecksum = 2'd2;

  typedef enum logic [1:0] {
    GP_BLANK,
    GP_COUNT,
    GP_LIT
  } group_phase_t;

  // Line and group state carried between data bytes
  typedef struct packed {
    group_phase_t group_phase;
    logic [7:0]   literals_left;
    logic [1:0]   line_length_seen;
    logic         held_blank;
  } group_state_t;

  typedef struct packed {
    logic [7:0] blank_run;
    logic       has_char;
    logic [7:0] character;
    logic       end_of_line;
    logic       end_of_stream;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ----- design/bcrd_group_decoder.sv -----
// Group decoder: expands one data byte into blanks, characters and line ends.
`default_nettype none

module bcrd_group_decoder (
  input  wire logic [7:0]            data_byte,
  input  wire bcrd_pkg::group_state_t grp,
  output bcrd_pkg::group_state_t      grp_next,
  output bcrd_pkg::result_t           res,
  output logic                        have
);

  // Saturating line length update, capped at two
  function automatic logic [1:0] grow(input logic [1:0] seen, input logic [7:0] amount);
    logic [8:0] sum;
    sum = {7'd0, seen} + {1'b0, amount};
    grow = (sum >= 9'd2) ? 2'd2 : sum[1:0];
  endfunction

  always_comb begin
    grp_next = grp;
    res      = '0;
    have     = 1'b0;
    case (grp.group_phase)
      bcrd_pkg::GP_BLANK: begin
        if (data_byte == bcrd_pkg::LineClose) begin
          // close the line, drop any held blank
          res.end_of_line            = 1'b1;
          have                       = 1'b1;
          grp_next.held_blank        = 1'b0;
          grp_next.line_length_seen  = 2'd0;
          grp_next.group_phase       = bcrd_pkg::GP_BLANK;
        end else begin
          grp_next.group_phase = bcrd_pkg::GP_COUNT;
          if (data_byte == 8'd0) begin
            have = 1'b0;
          end else if (grp.line_length_seen == 2'd0 && data_byte == 8'd1) begin
            // hold a lone leading blank
            grp_next.held_blank       = 1'b1;
            grp_next.line_length_seen = 2'd1;
          end else begin
            res.blank_run             = data_byte + {7'd0, grp.held_blank};
            have                      = 1'b1;
            grp_next.held_blank       = 1'b0;
            grp_next.line_length_seen = grow(grp.line_length_seen, data_byte);
          end
        end
      end
      bcrd_pkg::GP_COUNT: begin
        if (data_byte == bcrd_pkg::LineClose) begin
          res.end_of_line            = 1'b1;
          have                       = 1'b1;
          grp_next.held_blank        = 1'b0;
          grp_next.line_length_seen  = 2'd0;
          grp_next.group_phase       = bcrd_pkg::GP_BLANK;
        end else if (data_byte == 8'd0) begin
          grp_next.group_phase = bcrd_pkg::GP_BLANK;
        end else begin
          grp_next.literals_left = data_byte;
          grp_next.group_phase   = bcrd_pkg::GP_LIT;
        end
      end
      default: begin
        if (grp.line_length_seen == 2'd0 && data_byte == bcrd_pkg::SpaceChar) begin
          // a leading literal space is held like a blank
          grp_next.held_blank       = 1'b1;
          grp_next.line_length_seen = 2'd1;
        end else begin
          res.blank_run             = {7'd0, grp.held_blank};
          res.has_char              = 1'b1;
          res.character             = data_byte;
          have                      = 1'b1;
          grp_next.held_blank       = 1'b0;
          grp_next.line_length_seen = grow(grp.line_length_seen, 8'd1);
        end
        grp_next.literals_left = grp.literals_left - 8'd1;
        if (grp.literals_left == 8'd1) begin
          grp_next.group_phase = bcrd_pkg::GP_BLANK;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/blank_compressed_record_decoder_unit.sv -----
// Top level of the compressed record decoder: record framing, checksum, result register.
`default_nettype none

// Decodes an unblocked compressed record stream, one byte per transaction, into
// blank runs, literal characters and line ends. Each accepted byte gives at most
// one result; the whole update of record counters, the 16-bit data sum and the
// group decoder is combinational logic ahead of the result register, so the block
// sustains one byte per clock while the result side keeps up and stalls the input
// only while a waiting result is held. A bad record type byte (status 1) or a
// checksum mismatch at record end (status 2) gives one flagged result and halts
// the block; the end of the last record gives a result with end_of_stream set and
// also halts it. Once halted, bytes are still taken but give nothing until reset.
// RECORD_BYTES sets the padded size of a record that is not the last.
module blank_compressed_record_decoder_unit #(
  parameter int RECORD_BYTES = 120
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       stream_valid,
  output logic            stream_stall,
  input  wire logic [7:0] stream_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      blank_run,
  output logic            has_char,
  output logic [7:0]      character,
  output logic            end_of_line,
  output logic            end_of_stream,
  output logic [1:0]      status
);

  localparam logic [7:0] RecordBytesW = 8'(RECORD_BYTES);

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_HEADER,
    PH_DATA,
    PH_PAD
  } record_phase_t;

  record_phase_t          record_phase, record_phase_next;
  logic [7:0]             record_position, record_position_next;
  logic [7:0]             data_bytes_left, data_bytes_left_next;
  logic [15:0]            running_sum, running_sum_next;
  logic [15:0]            expected_sum, expected_sum_next;
  logic                   final_record, final_record_next;
  logic                   halted, halted_next;
  bcrd_pkg::group_state_t grp, grp_next, dec_grp_next;
  bcrd_pkg::result_t      res, dec_res, result;
  logic                   have, dec_have, done;
  logic                   accept;

  bcrd_group_decoder u_group (
    .data_byte (stream_byte),
    .grp       (grp),
    .grp_next  (dec_grp_next),
    .res       (dec_res),
    .have      (dec_have)
  );

  // Hold the input while a finished result waits
  assign stream_stall = result_valid && result_stall;
  assign accept       = stream_valid && !stream_stall;

  // Record framing, checksum and result selection
  always_comb begin
    record_phase_next    = record_phase;
    record_position_next = record_position;
    data_bytes_left_next = data_bytes_left;
    running_sum_next     = running_sum;
    expected_sum_next    = expected_sum;
    final_record_next    = final_record;
    halted_next          = halted;
    grp_next             = grp;
    res                  = '0;
    have                 = 1'b0;
    done                 = 1'b0;
    if (!halted) begin
      unique case (record_phase)
        PH_TYPE: begin
          if (stream_byte == bcrd_pkg::TypeMore || stream_byte == bcrd_pkg::TypeLast) begin
            final_record_next    = (stream_byte == bcrd_pkg::TypeLast);
            running_sum_next     = 16'd0;
            record_position_next = 8'd1;
            record_phase_next    = PH_HEADER;
          end else begin
            res.status  = bcrd_pkg::StBadType;
            halted_next = 1'b1;
            have        = 1'b1;
          end
        end
        PH_HEADER: begin
          if (record_position == bcrd_pkg::PosCount) begin
            data_bytes_left_next = stream_byte;
          end else if (record_position == bcrd_pkg::PosSumHigh) begin
            expected_sum_next[15:8] = stream_byte;
          end else if (record_position == bcrd_pkg::PosSumLow) begin
            expected_sum_next[7:0] = stream_byte;
          end
          if (record_position >= bcrd_pkg::PosLastHdr) begin
            record_position_next = bcrd_pkg::PosData;
            record_phase_next    = PH_DATA;
            done                 = (data_bytes_left == 8'd0);
          end else begin
            record_position_next = record_position + 8'd1;
          end
        end
        PH_DATA: begin
          running_sum_next     = running_sum + {8'd0, stream_byte};
          data_bytes_left_next = data_bytes_left - 8'd1;
          record_position_next = (record_position == 8'hff) ? record_position
                                                             : record_position + 8'd1;
          grp_next             = dec_grp_next;
          res                  = dec_res;
          have                 = dec_have;
          done                 = (data_bytes_left == 8'd1);
        end
        default: begin
          if (record_position + 8'd1 >= RecordBytesW || record_position == 8'hff) begin
            record_phase_next    = PH_TYPE;
            record_position_next = 8'd0;
          end else begin
            record_position_next = record_position + 8'd1;
          end
        end
      endcase

      // Check the sum at the end of a record's data, then end the stream or go on to padding or the next record
      if (done) begin
        if (running_sum_next != expected_sum_next) begin
          res         = '0;
          res.status  = bcrd_pkg::StChecksum;
          halted_next = 1'b1;
          have        = 1'b1;
        end else if (final_record) begin
          if (!have && grp_next.held_blank) begin
            res.blank_run = 8'd1;
          end
          res.end_of_stream = 1'b1;
          halted_next       = 1'b1;
          have              = 1'b1;
        end else if (record_position_next >= RecordBytesW) begin
          record_phase_next    = PH_TYPE;
          record_position_next = 8'd0;
        end else begin
          record_phase_next = PH_PAD;
        end
      end
    end
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      record_phase    <= PH_TYPE;
      record_position <= 8'd0;
      data_bytes_left <= 8'd0;
      running_sum     <= 16'd0;
      expected_sum    <= 16'd0;
      final_record    <= 1'b0;
      halted          <= 1'b0;
      grp             <= '{group_phase: bcrd_pkg::GP_BLANK, literals_left: 8'd0,
                           line_length_seen: 2'd0, held_blank: 1'b0};
    end else if (accept) begin
      record_phase    <= record_phase_next;
      record_position <= record_position_next;
      data_bytes_left <= data_bytes_left_next;
      running_sum     <= running_sum_next;
      expected_sum    <= expected_sum_next;
      final_record    <= final_record_next;
      halted          <= halted_next;
      grp             <= grp_next;
    end
  end

  // Result register: load on a result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && have) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && have) begin
      result <= res;
    end
  end

  assign blank_run     = result.blank_run;
  assign has_char      = result.has_char;
  assign character     = result.character;
  assign end_of_line   = result.end_of_line;
  assign end_of_stream = result.end_of_stream;
  assign status        = result.status;

`ifndef SYNTH
  // Once halted, only reset restarts the block
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted cleared without reset");

  // A flagged or final result always leaves the block halted
  a_flag_halts: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != bcrd_pkg::StOk || end_of_stream)) |-> halted)
    else $error("error or end of stream result without halt");

  // A held blank only exists as the sole content of a line
  a_held_blank: assert property (@(posedge clk) disable iff (rst)
    grp.held_blank |-> (grp.line_length_seen == 2'd1))
    else $error("held blank with wrong line length");
`endif

endmodule

`default_nettype wire

// ----- bench/blank_compressed_record_decoder_checker.sv -----
// Checker for the compressed record decoder: decodes the accepted byte stream and compares results.
`timescale 1ns / 100ps

module blank_compressed_record_decoder_checker #(
  parameter int RECORD_BYTES = 120
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       stream_valid,
  input  logic       stream_stall,
  input  logic [7:0] stream_byte,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [7:0] blank_run,
  input  logic       has_char,
  input  logic [7:0] character,
  input  logic       end_of_line,
  input  logic       end_of_stream,
  input  logic [1:0] status,
  output int         mismatches,
  output int         outstanding
);

  typedef enum logic [1:0] {
    REC_TYPE,
    REC_HEADER,
    REC_DATA,
    REC_PAD
  } rec_phase_t;

  // Decoder state as seen from the accepted byte stream
  rec_phase_t             rec_phase;
  logic [7:0]             rec_pos;
  logic [7:0]             data_left;
  logic [15:0]            data_sum;
  logic [15:0]            hdr_sum;
  logic                   last_rec;
  bcrd_pkg::group_phase_t grp_phase;
  logic [7:0]             lit_left;
  logic [1:0]             line_len;
  logic                   held_space;
  logic                   stopped;

  // Results decoded from accepted bytes and not yet seen at the output
  bcrd_pkg::result_t decoded_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic clear_decoder();
    rec_phase  = REC_TYPE;
    rec_pos    = '0;
    data_left  = '0;
    data_sum   = '0;
    hdr_sum    = '0;
    last_rec   = 1'b0;
    grp_phase  = bcrd_pkg::GP_BLANK;
    lit_left   = '0;
    line_len   = '0;
    held_space = 1'b0;
    stopped    = 1'b0;
  endtask

  // Grow the line length, saturating at two
  task automatic extend_line(input int amount);
    int v;
    v = int'(line_len) + amount;
    line_len = (v >= 2) ? 2'd2 : 2'(v);
  endtask

  task automatic close_line(inout bcrd_pkg::result_t r);
    r.end_of_line = 1'b1;
    held_space    = 1'b0;
    line_len      = '0;
    grp_phase     = bcrd_pkg::GP_BLANK;
  endtask

  // Advance the group decoder by one data byte
  task automatic decode_group_byte(input logic [7:0] b, inout bcrd_pkg::result_t r,
                                   output bit have);
    have = 1'b0;
    case (grp_phase)
      bcrd_pkg::GP_BLANK: begin
        if (b == bcrd_pkg::LineClose) begin
          close_line(r);
          have = 1'b1;
        end else begin
          grp_phase = bcrd_pkg::GP_COUNT;
          if (b == 8'h00) begin
            have = 1'b0;
          end else if (line_len == 2'd0 && b == 8'h01) begin
            // hold a lone leading blank until the line shows more content
            held_space = 1'b1;
            line_len   = 2'd1;
          end else begin
            r.blank_run = b + {7'b0, held_space};
            held_space  = 1'b0;
            extend_line(int'(b));
            have = 1'b1;
          end
        end
      end
      bcrd_pkg::GP_COUNT: begin
        if (b == bcrd_pkg::LineClose) begin
          close_line(r);
          have = 1'b1;
        end else if (b == 8'h00) begin
          grp_phase = bcrd_pkg::GP_BLANK;
        end else begin
          lit_left  = b;
          grp_phase = bcrd_pkg::GP_LIT;
        end
      end
      default: begin
        if (line_len == 2'd0 && b == bcrd_pkg::SpaceChar) begin
          held_space = 1'b1;
          line_len   = 2'd1;
        end else begin
          r.blank_run = {7'b0, held_space};
          r.has_char  = 1'b1;
          r.character = b;
          held_space  = 1'b0;
          extend_line(1);
          have = 1'b1;
        end
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) grp_phase = bcrd_pkg::GP_BLANK;
      end
    endcase
  endtask

  // Check the sum once the record's data is used up, then close or pad the record
  task automatic close_record_data(inout bcrd_pkg::result_t r, inout bit have);
    if (data_sum != hdr_sum) begin
      r        = '0;
      r.status = bcrd_pkg::StChecksum;
      stopped  = 1'b1;
      have     = 1'b1;
    end else if (last_rec) begin
      if (!have && held_space) r.blank_run = 8'd1;
      r.end_of_stream = 1'b1;
      stopped = 1'b1;
      have    = 1'b1;
    end else if (int'(rec_pos) >= RECORD_BYTES) begin
      rec_phase = REC_TYPE;
      rec_pos   = '0;
    end else begin
      rec_phase = REC_PAD;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, output bit have,
                             output bcrd_pkg::result_t r);
    have = 1'b0;
    r    = '0;
    if (!stopped) begin
      case (rec_phase)
        REC_TYPE: begin
          if (b == bcrd_pkg::TypeMore || b == bcrd_pkg::TypeLast) begin
            last_rec  = (b == bcrd_pkg::TypeLast);
            data_sum  = '0;
            rec_pos   = 8'd1;
            rec_phase = REC_HEADER;
          end else begin
            r.status = bcrd_pkg::StBadType;
            stopped  = 1'b1;
            have     = 1'b1;
          end
        end
        REC_HEADER: begin
          if (rec_pos == bcrd_pkg::PosCount) data_left = b;
          else if (rec_pos == bcrd_pkg::PosSumHigh) hdr_sum[15:8] = b;
          else if (rec_pos == bcrd_pkg::PosSumLow) hdr_sum[7:0] = b;
          if (rec_pos >= bcrd_pkg::PosLastHdr) begin
            rec_pos   = bcrd_pkg::PosData;
            rec_phase = REC_DATA;
            if (data_left == 8'd0) close_record_data(r, have);
          end else begin
            rec_pos = rec_pos + 8'd1;
          end
        end
        REC_DATA: begin
          data_sum  = data_sum + {8'h00, b};
          data_left = data_left - 8'd1;
          if (rec_pos != 8'hff) rec_pos = rec_pos + 8'd1;
          decode_group_byte(b, r, have);
          if (data_left == 8'd0) close_record_data(r, have);
        end
        default: begin
          if (rec_pos != 8'hff) rec_pos = rec_pos + 8'd1;
          if (int'(rec_pos) >= RECORD_BYTES) begin
            rec_phase = REC_TYPE;
            rec_pos   = '0;
          end
        end
      endcase
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare the output transaction first, then decode the input transaction
  always @(posedge clk) begin
    bcrd_pkg::result_t want;
    bcrd_pkg::result_t next;
    bit                have;
    if (rst) begin
      clear_decoder();
      decoded_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (decoded_results.size() == 0) begin
          $error("result with none outstanding: blank_run %0d has_char %0d character %0d",
                 blank_run, has_char, character);
          mismatches++;
        end else begin
          want = decoded_results.pop_front();
          compare_field("blank_run", want.blank_run, blank_run);
          compare_field("has_char", want.has_char, has_char);
          compare_field("character", want.character, character);
          compare_field("end_of_line", want.end_of_line, end_of_line);
          compare_field("end_of_stream", want.end_of_stream, end_of_stream);
          compare_field("status", want.status, status);
        end
      end
      if (stream_valid && !stream_stall) begin
        decode_byte(stream_byte, have, next);
        if (have) decoded_results.push_back(next);
      end
    end
    outstanding = decoded_results.size();
  end

endmodule

// ----- bench/tb_blank_compressed_record_decoder_unit.sv -----
// Testbench top of the compressed record decoder: clock, reset, record stream stimulus, verdict.
`timescale 1ns / 100ps

module tb_blank_compressed_record_decoder_unit;

  localparam int RecordBytes = 120;
  localparam int StreamBytes = 2000;
  localparam int CycleLimit  = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       stream_valid = 1'b0;
  logic       stream_stall;
  logic [7:0] stream_byte = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] blank_run;
  logic       has_char;
  logic [7:0] character;
  logic       end_of_line;
  logic       end_of_stream;
  logic [1:0] status;

  int mismatches;
  int outstanding;

  // Stimulus state
  int                     burst_left = 0;
  int                     sent_bytes = 0;
  int                     cycles = 0;
  int                     stall_hold = 0;
  int                     stall_mode = 0;
  int                     stall_tick = 0;
  bcrd_pkg::group_phase_t gen_phase = bcrd_pkg::GP_BLANK;
  logic [7:0]             gen_lits = 8'd0;
  logic [7:0]             record_data[$];

  blank_compressed_record_decoder_unit #(
    .RECORD_BYTES (RecordBytes)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .stream_valid  (stream_valid),
    .stream_stall  (stream_stall),
    .stream_byte   (stream_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .blank_run     (blank_run),
    .has_char      (has_char),
    .character     (character),
    .end_of_line   (end_of_line),
    .end_of_stream (end_of_stream),
    .status        (status)
  );

  blank_compressed_record_decoder_checker #(
    .RECORD_BYTES (RecordBytes)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .stream_valid  (stream_valid),
    .stream_stall  (stream_stall),
    .stream_byte   (stream_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .blank_run     (blank_run),
    .has_char      (has_char),
    .character     (character),
    .end_of_line   (end_of_line),
    .end_of_stream (end_of_stream),
    .status        (status),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stall the result side in stretches of changing pattern
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(32, 400);
    end
    stall_hold--;
    stall_tick++;
    case (stall_mode)
      0:       result_stall = 1'b0;
      1:       result_stall = ($urandom_range(0, 3) == 0);
      2:       result_stall = ($urandom_range(0, 3) != 0);
      default: result_stall = (stall_tick % 3 != 0);
    endcase
  end

  // Offer one byte, opening a gap between bursts, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      @(negedge clk);
      stream_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    stream_valid = 1'b1;
    stream_byte  = b;
    burst_left--;
    sent_bytes++;
    do @(posedge clk); while (stream_stall);
  endtask

  // Hold off the sender until every decoded result has been taken
  task automatic drain_results();
    @(negedge clk);
    stream_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Draw the next data byte, mostly well-formed groups with some noise
  task automatic pick_data_byte(output logic [7:0] b);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      b = 8'($urandom);
    end else begin
      pick = $urandom_range(0, 9);
      case (gen_phase)
        bcrd_pkg::GP_BLANK: begin
          if (pick == 0) b = 8'h00;
          else if (pick <= 3) b = 8'h01;
          else if (pick <= 5) b = bcrd_pkg::LineClose;
          else if (pick == 6) b = 8'($urandom_range(2, 254));
          else b = 8'($urandom_range(2, 12));
        end
        bcrd_pkg::GP_COUNT: begin
          if (pick == 0) b = 8'h00;
          else if (pick <= 2) b = bcrd_pkg::LineClose;
          else if (pick == 3) b = 8'($urandom_range(13, 60));
          else b = 8'($urandom_range(1, 8));
        end
        default: begin
          if (pick <= 2) b = bcrd_pkg::SpaceChar;
          else if (pick == 3) b = bcrd_pkg::LineClose;
          else b = 8'($urandom);
        end
      endcase
    end
    // track the group structure so later picks stay in step
    case (gen_phase)
      bcrd_pkg::GP_BLANK: if (b != bcrd_pkg::LineClose) gen_phase = bcrd_pkg::GP_COUNT;
      bcrd_pkg::GP_COUNT: begin
        if (b == bcrd_pkg::LineClose || b == 8'h00) begin
          gen_phase = bcrd_pkg::GP_BLANK;
        end else begin
          gen_lits  = b;
          gen_phase = bcrd_pkg::GP_LIT;
        end
      end
      default: begin
        gen_lits = gen_lits - 8'd1;
        if (gen_lits == 8'd0) gen_phase = bcrd_pkg::GP_BLANK;
      end
    endcase
  endtask

  task automatic fill_record(input int count);
    logic [7:0] b;
    record_data.delete();
    repeat (count) begin
      pick_data_byte(b);
      record_data.push_back(b);
    end
  endtask

  // Frame record_data with header and padding; optionally spoil the checksum
  task automatic send_record(input logic [7:0] kind_byte, input bit spoil_sum);
    logic [15:0] sum;
    int          pos;
    sum = '0;
    foreach (record_data[i]) sum += {8'h00, record_data[i]};
    if (spoil_sum) sum ^= 16'($urandom_range(1, 65535));
    send_byte(kind_byte);
    send_byte(8'(record_data.size()));
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    foreach (record_data[i]) send_byte(record_data[i]);
    if (kind_byte == bcrd_pkg::TypeMore) begin
      for (pos = 6 + record_data.size(); pos < RecordBytes; pos++) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int         records;
    int         pick;
    int         ending;
    logic [7:0] b;
    records = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero counts, lone blank lines, leading literal space,
    // literal 0xff and 0x00, wide blank run, then an empty record
    record_data = {8'h00, 8'h00, 8'h01, 8'hff, 8'hff, 8'h01, 8'h01, 8'h41,
                   8'hff, 8'h00, 8'h02, 8'h20, 8'hff, 8'hfe, 8'h00, 8'hff,
                   8'h01, 8'h00, 8'h05, 8'h00, 8'h00, 8'h01, 8'h00, 8'hff};
    send_record(bcrd_pkg::TypeMore, 1'b0);
    record_data.delete();
    send_record(bcrd_pkg::TypeMore, 1'b0);
    drain_results();

    // Random records, some empty and some too long to need padding
    while (sent_bytes < StreamBytes) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) fill_record(0);
      else if (pick == 1) fill_record($urandom_range(114, 255));
      else fill_record($urandom_range(1, 113));
      send_record(bcrd_pkg::TypeMore, 1'b0);
      records++;
      if (records % 8 == 0) drain_results();
    end

    // End the stream: last record, bad type byte or spoiled checksum
    ending = $urandom_range(0, 3);
    if (ending <= 1) begin
      fill_record(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40));
      send_record(bcrd_pkg::TypeLast, 1'b0);
    end else if (ending == 2) begin
      do b = 8'($urandom); while (b == bcrd_pkg::TypeMore || b == bcrd_pkg::TypeLast);
      send_byte(b);
    end else begin
      fill_record($urandom_range(0, 40));
      send_record(($urandom_range(0, 1) == 0) ? bcrd_pkg::TypeMore : bcrd_pkg::TypeLast,
                  1'b1);
    end

    // Bytes after the halt must be swallowed without results
    repeat (16) send_byte(8'($urandom));

    @(negedge clk);
    stream_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
